@@ rtl/eod_pkg.sv @@
// Shared types, constants and order-table helper functions for the elevator
// order dispatcher. No dependencies; used by the top level and its checker.
package eod_pkg;

  // Widest order table that the floor index below can address.
  localparam int MaxFloors     = 16;
  localparam int FloorIdxW     = 4;
  localparam int FloorsDefault = 4;

  // Beat widths on the two stream channels.
  localparam int InDataW  = 16;
  localparam int ResultW  = 19;
  localparam int OutDataW = 24;

  // Motor command, two's complement: -1 down, 0 stop, 1 up.
  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

  typedef logic [MaxFloors-1:0] fmask_t;

  // One result beat; the first member lands in the highest bits.
  typedef struct packed {
    logic [3:0] cab_lamps;
    logic [3:0] down_lamps;
    logic [3:0] up_lamps;
    logic [2:0] floor_indicator;
    logic       halted_between;
    logic       door_open;
    dir_t       motor_direction;
  } result_t;

  // Floors strictly above floor f.
  function automatic fmask_t above_mask(input logic [FloorIdxW-1:0] f);
    fmask_t m;
    for (int i = 0; i < MaxFloors; i++) begin
      m[i] = (FloorIdxW'(i) > f);
    end
    return m;
  endfunction

  // Floors strictly below floor f.
  function automatic fmask_t below_mask(input logic [FloorIdxW-1:0] f);
    fmask_t m;
    for (int i = 0; i < MaxFloors; i++) begin
      m[i] = (FloorIdxW'(i) < f);
    end
    return m;
  endfunction

  // Next direction from floor f, preferring to keep the current heading.
  function automatic dir_t pick_dir(input fmask_t any, input logic [FloorIdxW-1:0] f,
                                    input dir_t d);
    logic ab;
    logic be;
    logic hr;
    dir_t r;
    ab = |(any & above_mask(f));
    be = |(any & below_mask(f));
    hr = any[f];
    case (d)
      DIR_UP: begin
        r = ab ? DIR_UP : (hr ? DIR_STOP : (be ? DIR_DOWN : DIR_STOP));
      end
      DIR_DOWN: begin
        r = be ? DIR_DOWN : (hr ? DIR_STOP : (ab ? DIR_UP : DIR_STOP));
      end
      default: begin
        r = hr ? DIR_STOP : (ab ? DIR_UP : (be ? DIR_DOWN : DIR_STOP));
      end
    endcase
    return r;
  endfunction

  // Whether a moving car should stop at floor f.
  function automatic logic must_stop(input fmask_t up, input fmask_t dn, input fmask_t cab,
                                     input logic [FloorIdxW-1:0] f, input dir_t d);
    fmask_t any;
    logic   r;
    any = up | dn | cab;
    case (d)
      DIR_UP:   r = cab[f] || up[f] || (!(|(any & above_mask(f))) && dn[f]);
      DIR_DOWN: r = cab[f] || dn[f] || (!(|(any & below_mask(f))) && up[f]);
      default:  r = cab[f] || any[f];
    endcase
    return r;
  endfunction

endpackage

@@ rtl/elevator_order_dispatcher.sv @@
// Elevator order dispatcher, collective control, one poll tick per input beat.
// Depends on eod_pkg (types, direction codes, order-table helper functions).
//
//   channel | dir | payload
//   s_*     | in  | tdata[15:0]: up[3:0] down[7:4] cab[11:8] sensor[14:12] stop[15]
//   m_*     | out | tdata[23:0]: dir[1:0] door[2] halt[3] floor[6:4] lamps[18:7], pad
//
// One tick per clock while s_tready is high: the order table, floor and direction
// registers update on the accepting edge, which also registers the result beat.
// Reset gives an empty order table, an unknown floor and a stopped motor.
// A result register and a one-beat skid register decouple the sides, so s_tready
// falls only once two results wait; it comes back the cycle after m_tready.
module elevator_order_dispatcher #(
  parameter int FLOORS = eod_pkg::FloorsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // hall_up_buttons[3:0], hall_down_buttons[7:4], cab_buttons[11:8],
  // car_position[14:12], stop_pressed[15]
  input  logic [eod_pkg::InDataW-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // motor_direction[1:0], door_open[2], halted_between[3], floor_indicator[6:4],
  // up_lamps[10:7], down_lamps[14:11], cab_lamps[18:15], zero pad[23:19]
  output logic [eod_pkg::OutDataW-1:0] m_tdata
);

  localparam logic [eod_pkg::FloorIdxW:0] FloorCount = (eod_pkg::FloorIdxW + 1)'(FLOORS);

  // State registers.
  logic [FLOORS-1:0] ord_up;
  logic [FLOORS-1:0] ord_down;
  logic [FLOORS-1:0] ord_cab;
  logic [2:0]        last_floor;
  eod_pkg::dir_t     travel_direction;

  // Output stage and skid stage.
  logic             out_valid;
  eod_pkg::result_t out_data;
  logic             skid_valid;
  eod_pkg::result_t skid_data;

  // Input beat fields.
  logic [3:0] hall_up_buttons;
  logic [3:0] hall_down_buttons;
  logic [3:0] cab_buttons;
  logic [2:0] car_position;
  logic       stop_pressed;

  assign hall_up_buttons   = s_tdata[3:0];
  assign hall_down_buttons = s_tdata[7:4];
  assign cab_buttons       = s_tdata[11:8];
  assign car_position      = s_tdata[14:12];
  assign stop_pressed      = s_tdata[15];

  // Tick logic signals.
  eod_pkg::fmask_t               all_mask;
  eod_pkg::fmask_t               up0, dn0, cab0;
  eod_pkg::fmask_t               up1, dn1, cab1;
  eod_pkg::fmask_t               up2, dn2, cab2;
  eod_pkg::fmask_t               up3, dn3, cab3;
  eod_pkg::fmask_t               keep;
  logic                          at_floor;
  logic [eod_pkg::FloorIdxW-1:0] fidx;
  logic [eod_pkg::FloorIdxW-1:0] lidx;
  logic                          stop_a;
  logic                          stop_b;
  eod_pkg::dir_t                 dir1, dir2;
  logic [2:0]                    last_floor_next;
  eod_pkg::dir_t                 travel_direction_next;
  eod_pkg::result_t              result;

  logic accept;
  logic pop;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {(eod_pkg::OutDataW - eod_pkg::ResultW)'(0), out_data};

  // One poll tick: merge buttons, service the floor, apply stop, pick a heading.
  always_comb begin
    all_mask = eod_pkg::fmask_t'({FLOORS{1'b1}});
    up0  = eod_pkg::fmask_t'(ord_up)   | (eod_pkg::fmask_t'(hall_up_buttons)   & all_mask);
    dn0  = eod_pkg::fmask_t'(ord_down) | (eod_pkg::fmask_t'(hall_down_buttons) & all_mask);
    cab0 = eod_pkg::fmask_t'(ord_cab)  | (eod_pkg::fmask_t'(cab_buttons)       & all_mask);

    // A negative or too-high sensor reading counts as between floors.
    at_floor = !car_position[2] && ({3'b000, car_position[1:0]} < FloorCount);
    fidx     = eod_pkg::FloorIdxW'(car_position[1:0]);
    keep     = ~(eod_pkg::fmask_t'(1) << fidx);

    // Moving car reaching a floor it should stop at.
    stop_a = at_floor && (travel_direction != eod_pkg::DIR_STOP) &&
             eod_pkg::must_stop(up0, dn0, cab0, fidx, travel_direction);
    up1  = stop_a ? (up0 & keep)  : up0;
    dn1  = stop_a ? (dn0 & keep)  : dn0;
    cab1 = stop_a ? (cab0 & keep) : cab0;
    dir1 = stop_a ? eod_pkg::pick_dir(up1 | dn1 | cab1, fidx, travel_direction)
                  : travel_direction;

    // Idle car with orders at the current floor.
    stop_b = at_floor && (dir1 == eod_pkg::DIR_STOP) && ((up1 | dn1 | cab1) & ~keep) != '0;
    up2  = stop_b ? (up1 & keep)  : up1;
    dn2  = stop_b ? (dn1 & keep)  : dn1;
    cab2 = stop_b ? (cab1 & keep) : cab1;

    // Emergency stop drops every order and the heading.
    up3  = stop_pressed ? '0 : up2;
    dn3  = stop_pressed ? '0 : dn2;
    cab3 = stop_pressed ? '0 : cab2;
    dir2 = stop_pressed ? eod_pkg::DIR_STOP : dir1;

    last_floor_next = at_floor ? car_position : last_floor;
    lidx            = eod_pkg::FloorIdxW'(last_floor_next[1:0]);

    // An idle car at a known floor chooses where to go next.
    if (dir2 == eod_pkg::DIR_STOP && !last_floor_next[2]) begin
      travel_direction_next = eod_pkg::pick_dir(up3 | dn3 | cab3, lidx, eod_pkg::DIR_STOP);
    end else begin
      travel_direction_next = dir2;
    end

    result.motor_direction = travel_direction_next;
    result.door_open       = stop_a || stop_b || (stop_pressed && at_floor);
    result.halted_between  = stop_pressed && !at_floor;
    result.floor_indicator = last_floor_next;
    result.up_lamps        = up3[3:0];
    result.down_lamps      = dn3[3:0];
    result.cab_lamps       = cab3[3:0];
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      ord_up           <= '0;
      ord_down         <= '0;
      ord_cab          <= '0;
      last_floor       <= 3'b111;
      travel_direction <= eod_pkg::DIR_STOP;
    end else if (accept) begin
      ord_up           <= up3[FLOORS-1:0];
      ord_down         <= dn3[FLOORS-1:0];
      ord_cab          <= cab3[FLOORS-1:0];
      last_floor       <= last_floor_next;
      travel_direction <= travel_direction_next;
    end
  end

  // Result register with a one-beat skid behind it. A waiting skid beat blocks
  // the input, so a skid refill and a new accept never meet in one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept && (!out_valid || pop)) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else if (accept) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/eod_checker.sv @@
// Port-level checks for the elevator order dispatcher, bound to the top level.
// Depends on eod_pkg for beat widths and direction codes.
module eod_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [eod_pkg::OutDataW-1:0] m_tdata
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Input back-pressure only happens when a result is already waiting.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // Door pulse and halt request are never raised together.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
    else $error("door and halt both set");

  // A halt between floors leaves the motor stopped and every lamp dark.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |->
      m_tdata[1:0] == eod_pkg::DIR_STOP && m_tdata[eod_pkg::ResultW-1:7] == '0)
    else $error("halt with motion or pending orders");

  // Pad bits above the result stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[eod_pkg::OutDataW-1:eod_pkg::ResultW] == '0)
    else $error("nonzero pad bits in result beat");

endmodule

bind elevator_order_dispatcher eod_checker u_eod_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
